FILE: rtl/stpw_pkg.sv
// Shared types, constants and lookup functions for the stopwatch block.
// No dependencies; imported by stpw_rsp_fifo and stopwatch_display_uart_top.
`timescale 1ns / 1ps
`default_nettype none

package stpw_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int DIGIT_AW    = $clog2(DIGIT_COUNT);
   localparam int SEND_IDX_W  = 3;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SECOND   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_KEY_SCAN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_LIMIT        = 2'd2;

   localparam logic [7:0]  TPS_RESET   = 8'd200;
   localparam logic [3:0]  SCAN_RESET  = 4'd4;
   localparam logic [13:0] LIMIT_RESET = 14'd9999;

   localparam logic KIND_DISPLAY = 1'b0;
   localparam logic KIND_SERIAL  = 1'b1;

   localparam logic [3:0] DIGIT_MAX   = 4'd9;
   localparam logic [5:0] ASCII_ZERO  = 6'd48;

   // key held bits
   localparam int KEY_START = 0;
   localparam int KEY_PAUSE = 1;
   localparam int KEY_CLEAR = 2;

   typedef logic [3:0] digit_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] segment_pattern;
      logic [3:0] digit_enable;
      logic [5:0] tx_byte;
      logic       last;
   } result_type;

   // active-low segments, blank for anything that is not a decimal digit
   function automatic logic [7:0] seg_of(input digit_type d);
      logic [7:0] s;
      case (d)
         4'd0: s = 8'hC0;
         4'd1: s = 8'hF9;
         4'd2: s = 8'hA4;
         4'd3: s = 8'hB0;
         4'd4: s = 8'h99;
         4'd5: s = 8'h92;
         4'd6: s = 8'h82;
         4'd7: s = 8'hF8;
         4'd8: s = 8'h80;
         4'd9: s = 8'h90;
         default: s = 8'hFF;
      endcase
      return s;
   endfunction

   function automatic logic [5:0] ascii_of(input digit_type d);
      return ASCII_ZERO + {2'b00, d};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/stpw_rsp_fifo.sv
// Four-word result queue, up to two words written and one read per cycle.
// Depends on stpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stpw_rsp_fifo (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [1:0]                   push_count,
   input  wire stpw_pkg::result_type         push_word0,
   input  wire stpw_pkg::result_type         push_word1,
   input  wire logic                         pop,
   output stpw_pkg::result_type              head_word,
   output logic [stpw_pkg::FIFO_CW-1:0]      fill
);
   import stpw_pkg::*;

   result_type           entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   fill_ff, fill_in;
   logic [FIFO_AW-1:0]   wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + FIFO_AW'(1);
   assign wr_ptr_in   = wr_ptr_ff + FIFO_AW'(push_count);
   assign rd_ptr_in   = rd_ptr_ff + FIFO_AW'(pop);
   assign fill_in     = fill_ff + FIFO_CW'(push_count) - FIFO_CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_word0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_word1;
      end
   end

   assign head_word = entry_ff[rd_ptr_ff];
   assign fill      = fill_ff;

endmodule

`default_nettype wire

FILE: rtl/stopwatch_display_uart_top.sv
// Results: an accepted input word writes its result words, if any, into the result queue.
// Throughput: one input word per cycle unless stalled; a tick that starts a
// send yields two result words, drained one per cycle unless rsp_stall is high,
// from a four-word result queue. Input stalls while that queue holds more than
// two words (registered, so req_stall never depends on rsp_stall in the same cycle).
// Reset: synchronous; clears all state but the queue entries, loads register defaults 200 / 4 / 9999.
`timescale 1ns / 1ps
`default_nettype none

module stopwatch_display_uart_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input words
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_action,
   input  wire logic                            req_key_start,
   input  wire logic                            req_key_pause,
   input  wire logic                            req_key_clear,
   // result words
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_kind,
   output logic [7:0]                           rsp_segment_pattern,
   output logic [3:0]                           rsp_digit_enable,
   output logic [5:0]                           rsp_tx_byte,
   output logic                                 rsp_last,
   // register writes
   input  wire logic                            csr_write_enable,
   input  wire logic [stpw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [stpw_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import stpw_pkg::*;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [7:0]  tps_ff;         // ticks per second
   logic [3:0]  scan_ticks_ff;  // ticks per key scan
   logic [13:0] limit_ff;       // count limit

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff        <= TPS_RESET;
         scan_ticks_ff <= SCAN_RESET;
         limit_ff      <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TICKS_PER_SECOND:   tps_ff        <= csr_write_data[7:0];
            CSR_TICKS_PER_KEY_SCAN: scan_ticks_ff <= csr_write_data[3:0];
            CSR_COUNT_LIMIT:        limit_ff      <= csr_write_data[13:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Stopwatch state
   // ---------------------------------------------------------------
   logic [7:0]            prescale_ff, prescale_in;
   logic [3:0]            scan_count_ff, scan_count_in;
   logic                  second_due_ff, second_due_in;
   logic                  running_ff, running_in;
   logic [13:0]           seconds_ff, seconds_in;
   logic [2:0]            key_held_ff, key_held_in;
   logic [DIGIT_AW-1:0]   scan_pos_ff, scan_pos_in;
   digit_type             digit_ff [DIGIT_COUNT];   // BCD of the count, thousands first
   digit_type             digit_in [DIGIT_COUNT];
   logic [SEND_IDX_W-1:0] send_index_ff, send_index_in;
   logic                  send_busy_ff, send_busy_in;

   // result queue side
   logic [FIFO_CW-1:0]    fifo_fill;
   logic [1:0]            push_count;
   result_type            word0, word1, head_word;
   logic                  req_accept, rsp_pop;

   assign req_stall  = fifo_fill > FIFO_CW'(FIFO_DEPTH - 2);
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // Single-pass update for one accepted word
   // ---------------------------------------------------------------
   always_comb begin
      logic [7:0]  pre_inc;
      logic [3:0]  scan_inc;
      logic        scan_now;
      logic [2:0]  lvl;
      logic [2:0]  rel;
      logic        due_mid;
      logic        step;
      logic        start_req;
      logic        sent;
      logic        carry;

      prescale_in   = prescale_ff;
      scan_count_in = scan_count_ff;
      second_due_in = second_due_ff;
      running_in    = running_ff;
      seconds_in    = seconds_ff;
      key_held_in   = key_held_ff;
      scan_pos_in   = scan_pos_ff;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         digit_in[i] = digit_ff[i];
      end
      send_index_in = send_index_ff;
      send_busy_in  = send_busy_ff;

      pre_inc   = prescale_ff + 8'd1;
      scan_inc  = scan_count_ff + 4'd1;
      scan_now  = 1'b0;
      lvl       = {req_key_clear, req_key_pause, req_key_start};
      rel       = '0;
      due_mid   = 1'b0;
      step      = 1'b0;
      start_req = 1'b0;
      sent      = 1'b0;
      carry     = 1'b0;

      word0      = '0;
      word1      = '0;
      push_count = 2'd0;

      if (req_accept && req_action) begin
         // serial done: release the next byte, or go idle
         if (send_busy_ff && (send_index_ff < SEND_IDX_W'(DIGIT_COUNT))) begin
            word0.kind    = KIND_SERIAL;
            word0.tx_byte = ascii_of(digit_ff[send_index_ff[DIGIT_AW-1:0]]);
            word0.last    = 1'b1;
            send_index_in = send_index_ff + SEND_IDX_W'(1);
            push_count    = 2'd1;
         end else begin
            send_busy_in = 1'b0;
         end
      end else if (req_accept) begin
         // display refresh from the digits as they stand before this tick
         word0.kind            = KIND_DISPLAY;
         word0.segment_pattern = seg_of(digit_ff[scan_pos_ff]);
         word0.digit_enable    = ~(DIGIT_COUNT'(1) << scan_pos_ff);
         scan_pos_in           = scan_pos_ff + DIGIT_AW'(1);

         // timebase; the second mark sees the run flag from before the key scan
         if (scan_inc >= scan_ticks_ff) begin
            scan_count_in = 4'd0;
            scan_now      = 1'b1;
         end else begin
            scan_count_in = scan_inc;
         end
         if ((pre_inc >= tps_ff) && running_ff) begin
            prescale_in = 8'd0;
            due_mid     = 1'b1;
         end else begin
            prescale_in = pre_inc;
            due_mid     = second_due_ff;
         end

         // keys act on release; start, then pause, then clear
         if (scan_now) begin
            for (int k = 0; k < 3; k++) begin
               if (!lvl[k]) begin
                  key_held_in[k] = 1'b1;
               end else if (key_held_ff[k]) begin
                  key_held_in[k] = 1'b0;
                  rel[k]         = 1'b1;
               end
            end
         end
         if (rel[KEY_START]) begin
            running_in = 1'b1;
         end
         if (rel[KEY_PAUSE]) begin
            running_in = 1'b0;
         end
         if (rel[KEY_CLEAR]) begin
            running_in = 1'b0;
            seconds_in = 14'd0;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               digit_in[i] = '0;
            end
            start_req = 1'b1;
         end

         // seconds step; clear stops the count, so it never meets a step
         step          = due_mid && running_in;
         second_due_in = due_mid && !running_in;
         if (step) begin
            start_req = 1'b1;
            if (seconds_ff >= limit_ff) begin
               seconds_in = 14'd0;
               for (int i = 0; i < DIGIT_COUNT; i++) begin
                  digit_in[i] = '0;
               end
            end else begin
               seconds_in = seconds_ff + 14'd1;
               // BCD increment, units first; digits track the count mod 10000
               carry = 1'b1;
               for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
                  if (carry) begin
                     if (digit_ff[i] >= DIGIT_MAX) begin
                        digit_in[i] = '0;
                     end else begin
                        digit_in[i] = digit_ff[i] + 4'd1;
                        carry       = 1'b0;
                     end
                  end
               end
            end
         end

         // a send already running keeps going on the updated digits
         if (start_req && !send_busy_ff) begin
            sent          = 1'b1;
            send_busy_in  = 1'b1;
            send_index_in = SEND_IDX_W'(1);
            word1.kind    = KIND_SERIAL;
            word1.tx_byte = ascii_of(digit_in[0]);
            word1.last    = 1'b1;
         end

         word0.last = !sent;
         push_count = sent ? 2'd2 : 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff   <= '0;
         scan_count_ff <= '0;
         second_due_ff <= 1'b0;
         running_ff    <= 1'b0;
         seconds_ff    <= '0;
         key_held_ff   <= '0;
         scan_pos_ff   <= '0;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_ff[i] <= '0;
         end
         send_index_ff <= '0;
         send_busy_ff  <= 1'b0;
      end else begin
         prescale_ff   <= prescale_in;
         scan_count_ff <= scan_count_in;
         second_due_ff <= second_due_in;
         running_ff    <= running_in;
         seconds_ff    <= seconds_in;
         key_held_ff   <= key_held_in;
         scan_pos_ff   <= scan_pos_in;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_ff[i] <= digit_in[i];
         end
         send_index_ff <= send_index_in;
         send_busy_ff  <= send_busy_in;
      end
   end

   // ---------------------------------------------------------------
   // Result queue and output port
   // ---------------------------------------------------------------
   assign rsp_valid = fifo_fill != '0;
   assign rsp_pop   = rsp_valid && !rsp_stall;

   stpw_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_word0 (word0),
      .push_word1 (word1),
      .pop        (rsp_pop),
      .head_word  (head_word),
      .fill       (fifo_fill)
   );

   assign rsp_kind            = head_word.kind;
   assign rsp_segment_pattern = head_word.segment_pattern;
   assign rsp_digit_enable    = head_word.digit_enable;
   assign rsp_tx_byte         = head_word.tx_byte;
   assign rsp_last            = head_word.last;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
`ifndef SYNTHESIS
   // stall threshold must keep room for a two-word tick
   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_fill <= FIFO_CW'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_send_index_range: assert property (@(posedge clock) disable iff (reset)
      send_index_ff <= SEND_IDX_W'(DIGIT_COUNT))
      else $error("send index past last digit");

   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      digit_ff[0] <= DIGIT_MAX && digit_ff[1] <= DIGIT_MAX &&
      digit_ff[2] <= DIGIT_MAX && digit_ff[3] <= DIGIT_MAX)
      else $error("digit store holds a non-decimal digit");

   // a send that starts always begins at the second byte index
   a_send_start: assert property (@(posedge clock) disable iff (reset)
      $rose(send_busy_ff) |-> send_index_ff == SEND_IDX_W'(1))
      else $error("send started at wrong index");
`endif

endmodule

`default_nettype wire
